// File: hw/rtl/slsd_pkg.sv
// ----------------------------------------------------------------------------
// slsd_pkg
// Shared types and constants of the linked-list symmetric difference block.
// ----------------------------------------------------------------------------
`default_nettype none
package slsd_pkg;
    localparam int DEPTH_DEFAULT = 1024;
    localparam int VAL_W = 32;
    localparam int SLOT_W = 10;
    localparam int REQ_W = 3;

    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TOGGLE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LOCATE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;
endpackage
`default_nettype wire

// File: hw/rtl/slsd_ram.sv
// ----------------------------------------------------------------------------
// slsd_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module slsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/static_list_symmetric_difference_top.sv
// ----------------------------------------------------------------------------
// static_list_symmetric_difference_top
// Linked list in a node store with a free list, forming the symmetric
// difference of two sets.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis group: tdata holds req_type then value.
// Each request gives one response on m_axis: tdata holds status, hit,
// slot, elem_out and last from the lowest bit up.
// The block works on one request at a time.  Append passes through the
// states RD1, RD2, LINK3, LINK1 and LINK2, and read through RD1, RDX and
// RDY, before the response.  Toggle and locate walk the list with one
// memory read pair per node.
// Clear and reset rebuild the free chain by writing every link entry,
// one per cycle, and no request is taken until the rebuild is done.
// While the receiver stalls the response is held and the next request
// waits until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module static_list_symmetric_difference_top #(
    parameter int DEPTH = slsd_pkg::DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // req_type[2:0], value[34:3], zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata   // status, hit, slot, elem_out, last
);
    localparam int AW = $clog2(DEPTH);
    localparam int SW = slsd_pkg::SLOT_W;
    localparam int VW = slsd_pkg::VAL_W;
    localparam logic [AW-1:0] LASTA = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ONE = AW'(1);
    localparam logic [AW-1:0] TWO = AW'(2);
    localparam logic [AW:0] DEPTHW = (AW+1)'(DEPTH);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD1, S_RD2, S_WALK_A, S_WALK_B, S_LINK1, S_LINK2,
        S_LINK3, S_RDX, S_RDY, S_OUT
    } state_t;

    state_t state_reg;
    logic [AW-1:0] free_head_reg, tail_reg, cursor_reg, p_reg, k_reg, stop_reg;
    logic [AW-1:0] n_reg, tnext_reg;
    logic [AW:0] steps_reg;
    logic [AW-1:0] init_reg;
    logic [2:0] req_reg;
    logic [VW-1:0] val_reg;
    logic [1:0] status_reg;
    logic hit_reg, last_reg;
    logic [AW-1:0] slot_reg;
    logic [VW-1:0] elem_reg;

    logic l_we, v_we;
    logic [AW-1:0] l_addr, v_addr, l_wdata, l_rdata;
    logic [VW-1:0] v_rdata;

    slsd_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_links (
        .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata));
    slsd_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_values (
        .clk(clk), .we(v_we), .addr(v_addr), .wdata(val_reg), .rdata(v_rdata));

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = {2'd0, last_reg, elem_reg, SW'(slot_reg), hit_reg, status_reg};

    logic [2:0] in_req;
    assign in_req = s_axis_tdata[2:0];

    always_comb
    begin
        l_we = 1'b0;
        l_addr = k_reg;
        l_wdata = '0;
        v_we = 1'b0;
        v_addr = k_reg;
        case (state_reg)
            S_INIT:
            begin
                l_we = 1'b1;
                l_addr = init_reg;
                l_wdata = (init_reg == LASTA || init_reg < TWO) ? '0 : init_reg + ONE;
            end
            S_IDLE: l_addr = s_axis_tdata[2:0] == slsd_pkg::REQ_READ && cursor_reg != '0
                             ? cursor_reg : ONE;
            S_RD1: l_addr = tail_reg;
            S_RD2: l_addr = n_reg;
            S_WALK_A:
            begin
                l_addr = k_reg;
                v_addr = k_reg;
            end
            S_LINK1:
            begin
                if (hit_reg)
                begin
                    l_we = 1'b1; l_addr = p_reg; l_wdata = n_reg;
                end
                else
                begin
                    l_we = 1'b1; l_addr = n_reg; l_wdata = tnext_reg;
                    v_we = 1'b1; v_addr = n_reg;
                end
            end
            S_LINK2:
            begin
                l_we = 1'b1;
                if (hit_reg)
                begin
                    l_addr = k_reg; l_wdata = free_head_reg;
                end
                else
                begin
                    l_addr = tail_reg; l_wdata = n_reg;
                end
            end
            S_RDX:
            begin
                l_addr = n_reg;
                v_addr = n_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            init_reg <= '0;
            free_head_reg <= TWO;
            tail_reg <= ONE;
            cursor_reg <= '0;
            req_reg <= slsd_pkg::REQ_READ;
        end
        else
        begin
            case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + ONE;
                    if (init_reg == LASTA)
                    begin
                        state_reg <= (req_reg == slsd_pkg::REQ_CLEAR) ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        req_reg <= in_req;
                        val_reg <= s_axis_tdata[34:3];
                        status_reg <= slsd_pkg::ST_OK;
                        hit_reg <= 1'b0;
                        last_reg <= 1'b0;
                        slot_reg <= '0;
                        elem_reg <= '0;
                        steps_reg <= '0;
                        case (in_req)
                            slsd_pkg::REQ_CLEAR:
                            begin
                                init_reg <= '0;
                                free_head_reg <= TWO;
                                tail_reg <= ONE;
                                cursor_reg <= '0;
                                state_reg <= S_INIT;
                            end
                            slsd_pkg::REQ_APPEND, slsd_pkg::REQ_TOGGLE,
                            slsd_pkg::REQ_LOCATE, slsd_pkg::REQ_READ:
                                state_reg <= S_RD1;
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_RD1:
                begin
                    // Link of slot 1 (or of the cursor for a read).
                    k_reg <= l_rdata;
                    p_reg <= ONE;
                    case (req_reg)
                        slsd_pkg::REQ_LOCATE:
                        begin
                            state_reg <= S_WALK_A;
                        end
                        slsd_pkg::REQ_READ:
                        begin
                            if (l_rdata == '0)
                            begin
                                status_reg <= slsd_pkg::ST_END;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                n_reg <= l_rdata;
                                state_reg <= S_RDX;
                            end
                        end
                        default:
                        begin
                            n_reg <= free_head_reg;
                            state_reg <= S_RD2;
                        end
                    endcase
                end
                S_RD2:
                begin
                    // Link of the A tail.
                    if (steps_reg != '1)
                    begin
                        tnext_reg <= l_rdata;
                        stop_reg <= l_rdata;
                    end
                    if (req_reg == slsd_pkg::REQ_TOGGLE)
                    begin
                        state_reg <= S_WALK_A;
                    end
                    else if (free_head_reg == '0)
                    begin
                        status_reg <= slsd_pkg::ST_FULL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_LINK3;
                    end
                end
                S_LINK3:
                begin
                    // Link of the free head node arrives.
                    free_head_reg <= l_rdata;
                    state_reg <= S_LINK1;
                end
                S_WALK_A:
                begin
                    if ((req_reg == slsd_pkg::REQ_TOGGLE && k_reg == stop_reg) ||
                        (req_reg == slsd_pkg::REQ_LOCATE && k_reg == '0) ||
                        steps_reg >= DEPTHW)
                    begin
                        if (req_reg == slsd_pkg::REQ_LOCATE)
                        begin
                            state_reg <= S_OUT;
                        end
                        else if (free_head_reg == '0)
                        begin
                            status_reg <= slsd_pkg::ST_FULL;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            n_reg <= free_head_reg;
                            state_reg <= S_RD2;
                            req_reg <= slsd_pkg::REQ_APPEND;
                            hit_reg <= 1'b0;
                            steps_reg <= '1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_WALK_B;
                    end
                end
                S_WALK_B:
                begin
                    if (v_rdata == val_reg)
                    begin
                        hit_reg <= 1'b1;
                        slot_reg <= k_reg;
                        if (req_reg == slsd_pkg::REQ_LOCATE)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            n_reg <= l_rdata;
                            state_reg <= S_LINK1;
                        end
                    end
                    else
                    begin
                        p_reg <= k_reg;
                        k_reg <= l_rdata;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_WALK_A;
                    end
                end
                S_LINK1:
                begin
                    state_reg <= S_LINK2;
                end
                S_LINK2:
                begin
                    cursor_reg <= '0;
                    if (hit_reg)
                    begin
                        free_head_reg <= k_reg;
                        if (tail_reg == k_reg)
                        begin
                            tail_reg <= p_reg;
                        end
                    end
                    else
                    begin
                        slot_reg <= n_reg;
                        if (steps_reg != '1)
                        begin
                            tail_reg <= n_reg;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_RDX:
                begin
                    state_reg <= S_RDY;
                end
                S_RDY:
                begin
                    cursor_reg <= n_reg;
                    slot_reg <= n_reg;
                    elem_reg <= v_rdata;
                    last_reg <= (l_rdata == '0);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("response changed while stalled");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request taken while response pending");
    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == slsd_pkg::ST_FULL |-> m_axis_tdata[12:3] == '0)
        else $error("full status with nonzero slot");
`endif
endmodule
`default_nettype wire
